@@ hdl/xtea_pkg.sv @@
package xtea_pkg;

    // Round constant of the cipher
    localparam logic [31:0] XTEA_DELTA = 32'h9E37_79B9;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int RC_W       = 7;
    localparam int ROUNDS_W   = 8;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY0   = 3'd0,
        REG_KEY1   = 3'd1,
        REG_KEY2   = 3'd2,
        REG_KEY3   = 3'd3,
        REG_ROUNDS = 3'd4
    } t_cfg_reg;

    typedef logic [3:0][31:0] t_key;

    // Settings seen by the datapath
    typedef struct packed {
        t_key                key;
        logic [ROUNDS_W-1:0] rounds;   // round count after saturation
        logic [31:0]         dec_sum;  // starting sum for decryption
    } t_cfg;

    // One block in flight: the half to update is a, the other half is b
    typedef struct packed {
        logic        dec;
        logic        phase;   // 0: first half round, 1: second half round
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] sum;
    } t_blk;

    function automatic logic [31:0] xtea_mix(input logic [31:0] x);
        return ((x << 4) ^ (x >> 5)) + x;
    endfunction

    // Clamp a programmed round count to the supported maximum
    function automatic logic [ROUNDS_W-1:0] sat_rounds(input logic [RC_W-1:0] rc,
                                                       input logic [ROUNDS_W-1:0] max_r);
        logic [ROUNDS_W-1:0] rc_ext;
        rc_ext = ROUNDS_W'(rc);
        return (rc_ext > max_r) ? max_r : rc_ext;
    endfunction

endpackage

@@ hdl/xtea_cfg_regs.sv @@
module xtea_cfg_regs #(
    parameter int MAX_ROUNDS = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [xtea_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [xtea_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output xtea_pkg::t_cfg                     o_cfg
);
    import xtea_pkg::*;

    localparam logic [ROUNDS_W-1:0] MAX_R      = ROUNDS_W'(MAX_ROUNDS);
    localparam logic [ROUNDS_W-1:0] RST_ROUNDS = (MAX_ROUNDS < 32) ? MAX_R : 8'd32;
    localparam logic [31:0]         RST_SUM    = 32'(XTEA_DELTA * 32'(RST_ROUNDS));

    t_key                r_key;
    logic [ROUNDS_W-1:0] r_rounds;
    logic [31:0]         r_dec_sum;
    logic [ROUNDS_W-1:0] n_rounds;

    // Clamp the written round count before it is stored
    assign n_rounds = sat_rounds(i_cfg_data[RC_W-1:0], MAX_R);

    // Decode writes; the decryption start sum is kept alongside the round count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key     <= '0;
            r_rounds  <= RST_ROUNDS;
            r_dec_sum <= RST_SUM;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx) inside
                REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: begin
                    r_key[i_cfg_idx[1:0]] <= i_cfg_data;
                end
                REG_ROUNDS: begin
                    r_rounds  <= n_rounds;
                    r_dec_sum <= XTEA_DELTA * 32'(n_rounds);
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = '{key: r_key, rounds: r_rounds, dec_sum: r_dec_sum};

endmodule

@@ hdl/xtea_cell.sv @@
module xtea_cell #(
    parameter int CNT_W = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  xtea_pkg::t_key     i_key,
    input  logic               i_vld,
    input  logic [CNT_W-1:0]   i_cnt,
    input  xtea_pkg::t_blk     i_blk,
    output logic               o_vld,
    output logic [CNT_W-1:0]   o_cnt,
    output xtea_pkg::t_blk     o_blk
);
    import xtea_pkg::*;

    logic             r_vld;
    logic [CNT_W-1:0] r_cnt;
    t_blk             r_blk;

    logic [1:0]       key_sel;
    logic [31:0]      f_val;
    logic [31:0]      a_new;
    logic [31:0]      sum_new;

    // Hold the block handed over by the previous cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= i_cnt;
        r_blk <= i_blk;
    end

    // One half round: update a from b, then swap the halves for the next cell
    always_comb begin
        key_sel = (r_blk.phase ^ r_blk.dec) ? r_blk.sum[12:11] : r_blk.sum[1:0];
        f_val   = xtea_mix(r_blk.b) ^ (r_blk.sum + i_key[key_sel]);
        a_new   = r_blk.dec ? (r_blk.a - f_val) : (r_blk.a + f_val);
        if (r_blk.phase) begin
            sum_new = r_blk.sum;
        end else if (r_blk.dec) begin
            sum_new = r_blk.sum - XTEA_DELTA;
        end else begin
            sum_new = r_blk.sum + XTEA_DELTA;
        end
    end

    assign o_vld = r_vld;
    assign o_cnt = r_cnt - CNT_W'(1);
    assign o_blk = '{dec: r_blk.dec, phase: ~r_blk.phase, a: r_blk.b, b: a_new,
                     sum: sum_new};

endmodule

@@ hdl/xtea_block_cipher_core.sv @@
// XTEA cipher core: pulse start with a 64-bit block and an action bit (0 encrypt,
// 1 decrypt) while busy is low; the block is taken at that edge. Blocks circulate
// through a ring of NUM_CELLS half-round cells, one half round per cell per cycle,
// so a block with R rounds (round_count clamped to MAX_ROUNDS) runs all its half
// rounds in the ring and then reports on o_done through a register, and a round
// count of zero reports on the next cycle. Up to NUM_CELLS blocks share the ring,
// so a new block can be taken while earlier blocks are still in flight; busy is
// high while a block in the last cell is about to wrap into the first one. Results
// leave in the order the blocks came in. o_done and the result words are valid
// for exactly one cycle and the receiver cannot stall them, so capture the result
// on that cycle. Configuration writes take effect at once and belong to idle time.
module xtea_block_cipher_core #(
    parameter int MAX_ROUNDS = 64,   // 1 to 255
    parameter int NUM_CELLS  = 2     // 1 or more
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [xtea_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [xtea_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_action,
    input  logic [31:0]                        i_left_half,
    input  logic [31:0]                        i_right_half,
    output logic                               o_done,
    output logic [31:0]                        o_left_out,
    output logic [31:0]                        o_right_out
);
    import xtea_pkg::*;

    localparam int CNT_W = $clog2(2 * MAX_ROUNDS + 1);

    t_cfg             cfg;

    logic             cell_in_vld  [NUM_CELLS];
    logic [CNT_W-1:0] cell_in_cnt  [NUM_CELLS];
    t_blk             cell_in_blk  [NUM_CELLS];
    logic             cell_out_vld [NUM_CELLS];
    logic [CNT_W-1:0] cell_out_cnt [NUM_CELLS];
    t_blk             cell_out_blk [NUM_CELLS];
    logic [NUM_CELLS-1:0] fin_vec;

    logic             wrap;
    logic             accept;
    logic             zero_rounds;
    t_blk             new_blk;
    t_blk             fin_blk;

    logic             r_done;
    logic [31:0]      r_left;
    logic [31:0]      r_right;
    logic             n_done;
    logic [31:0]      n_left;
    logic [31:0]      n_right;

    xtea_cfg_regs #(
        .MAX_ROUNDS (MAX_ROUNDS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Ring of half-round cells
    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        xtea_cell #(
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_key   (cfg.key),
            .i_vld   (cell_in_vld[g]),
            .i_cnt   (cell_in_cnt[g]),
            .i_blk   (cell_in_blk[g]),
            .o_vld   (cell_out_vld[g]),
            .o_cnt   (cell_out_cnt[g]),
            .o_blk   (cell_out_blk[g])
        );

        // A block with no half rounds left drops out of the ring
        assign fin_vec[g] = cell_out_vld[g] && (cell_out_cnt[g] == '0);

        if (g > 0) begin : g_link
            assign cell_in_vld[g] = cell_out_vld[g-1] && (cell_out_cnt[g-1] != '0);
            assign cell_in_cnt[g] = cell_out_cnt[g-1];
            assign cell_in_blk[g] = cell_out_blk[g-1];
        end
    end

    // Entry into the first cell: a wrapping block has the slot, else a new one
    assign wrap        = cell_out_vld[NUM_CELLS-1] && (cell_out_cnt[NUM_CELLS-1] != '0);
    assign busy        = wrap;
    assign accept      = start && !busy;
    assign zero_rounds = (cfg.rounds == '0);

    always_comb begin
        new_blk.dec   = i_action;
        new_blk.phase = 1'b0;
        new_blk.a     = i_action ? i_right_half : i_left_half;
        new_blk.b     = i_action ? i_left_half  : i_right_half;
        new_blk.sum   = i_action ? cfg.dec_sum  : 32'd0;
    end

    assign cell_in_vld[0] = wrap || (accept && !zero_rounds);
    assign cell_in_cnt[0] = wrap ? cell_out_cnt[NUM_CELLS-1]
                                 : CNT_W'({1'b0, cfg.rounds, 1'b0});
    assign cell_in_blk[0] = wrap ? cell_out_blk[NUM_CELLS-1] : new_blk;

    // Pick the finishing block; at most one cell finishes in a cycle
    always_comb begin
        fin_blk = cell_out_blk[0];
        for (int k = 0; k < NUM_CELLS; k++) begin
            if (fin_vec[k]) begin
                fin_blk = cell_out_blk[k];
            end
        end
    end

    // Drive the result for one cycle; a zero-round block passes straight through
    always_comb begin
        n_done  = 1'b0;
        n_left  = fin_blk.dec ? fin_blk.b : fin_blk.a;
        n_right = fin_blk.dec ? fin_blk.a : fin_blk.b;
        if (accept && zero_rounds) begin
            n_done  = 1'b1;
            n_left  = i_left_half;
            n_right = i_right_half;
        end else if (|fin_vec) begin
            n_done  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left  <= n_left;
        r_right <= n_right;
    end

    assign o_done      = r_done;
    assign o_left_out  = r_left;
    assign o_right_out = r_right;

    // Two blocks in the ring never finish in the same cycle
    a_one_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(fin_vec) <= 1)
        else $error("two cells finished in one cycle");

    // A result only follows a transfer in or a block leaving the ring
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(start && !busy) || $past(|fin_vec)))
        else $error("result without a source block");

    // A zero-round block is reported on the next cycle
    a_zero_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && zero_rounds) |=> o_done)
        else $error("zero-round block not passed through");

    // A block with rounds to run lands in the first cell
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !zero_rounds) |=> cell_out_vld[0])
        else $error("accepted block lost at ring entry");

endmodule
